### hdl/plse_pkg.sv
// Shared types and constants of the product-limit survival estimator.
`timescale 1ns / 1ps

package plse_pkg;

  localparam int IdxW  = 13;
  localparam int PosW  = 12;
  localparam int ProbW = 32;
  localparam int ArW   = 33;
  localparam int GwW   = 48;
  localparam int MulXW = 34;
  localparam int MulYW = 17;
  localparam int MulPW = MulXW + MulYW;
  localparam int UnitW = 68;
  localparam int AddrW = 4;

  localparam logic [ProbW-1:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [GwW-1:0]   GW_MAX  = {GwW{1'b1}};

  typedef enum logic [1:0] {
    REG_MODE      = 2'd0,
    REG_COUNT     = 2'd1,
    REG_FWD_START = 2'd2,
    REG_REV_STOP  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic            reverse_mode;
    logic [IdxW-1:0] interval_count;
    logic [IdxW-1:0] forward_start_index;
    logic [IdxW-1:0] reverse_stop_index;
  } cfg_t;

endpackage

### hdl/plse_cfg.sv
// Configuration register bank behind the APB-style port.
`timescale 1ns / 1ps

module plse_cfg
  import plse_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output cfg_t             cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[3:2]);
  assign wr_en = psel & penable & pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reverse_mode        <= 1'b0;
      cfg_r.interval_count      <= 13'd1;
      cfg_r.forward_start_index <= 13'd1;
      cfg_r.reverse_stop_index  <= 13'd4096;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE:      cfg_r.reverse_mode        <= pwdata[0];
        REG_COUNT:     cfg_r.interval_count      <= pwdata[IdxW-1:0];
        REG_FWD_START: cfg_r.forward_start_index <= pwdata[IdxW-1:0];
        REG_REV_STOP:  cfg_r.reverse_stop_index  <= pwdata[IdxW-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MODE:      prdata = {31'b0, cfg_r.reverse_mode};
      REG_COUNT:     prdata = {19'b0, cfg_r.interval_count};
      REG_FWD_START: prdata = {19'b0, cfg_r.forward_start_index};
      REG_REV_STOP:  prdata = {19'b0, cfg_r.reverse_stop_index};
    endcase
  end

endmodule

### hdl/plse_sub.sv
// Shared wide compare-and-subtract unit for division and square root steps.
`timescale 1ns / 1ps

module plse_sub
  import plse_pkg::*;
(
  input  logic [UnitW-1:0] opa,
  input  logic [UnitW-1:0] opb,
  output logic [UnitW-1:0] diff,
  output logic             ge
);

  logic [UnitW:0] full;

  assign full = {1'b0, opa} - {1'b0, opb};
  assign diff = full[UnitW-1:0];
  assign ge   = ~full[UnitW];

endmodule

### hdl/plse_mul.sv
// Partial-product multiplier with a registered product.
`timescale 1ns / 1ps

module plse_mul
  import plse_pkg::*;
(
  input  logic             clk,
  input  logic [MulXW-1:0] x,
  input  logic [MulYW-1:0] y,
  output logic [MulPW-1:0] p_r
);

  logic [MulPW-1:0] p_nxt;

  assign p_nxt = MulPW'(x) * MulPW'(y);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

### hdl/plse_seq.sv
// Sequencer and datapath registers that walk one interval through the shared units.
`timescale 1ns / 1ps

module plse_seq
  import plse_pkg::*;
#(
  parameter int MAX_INTERVALS = 4096,
  parameter int COUNT_BITS    = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COUNT_BITS-1:0] in_entering_count,
  input  logic [COUNT_BITS-1:0] in_failures_first_kind,
  input  logic [COUNT_BITS-1:0] in_failures_second_kind,
  input  logic [COUNT_BITS-1:0] in_lost_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PosW-1:0]       out_position,
  output logic [ProbW-1:0]      out_probability,
  output logic [31:0]           out_std_error,
  output logic                  out_last_of_run
);

  localparam int FtW = COUNT_BITS + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HCHK, ST_HDIV, ST_MLO, ST_MHI, ST_MADD, ST_GCHK,
    ST_GDIV, ST_GSUM, ST_SQ, ST_AR, ST_EMIT, ST_FINAL
  } state_t;

  typedef enum logic [1:0] {MK_SURV, MK_DEN, MK_ERR} mkind_t;

  function automatic logic [ArW-1:0] sat_ar(input logic [35:0] v);
    logic [ArW-1:0] r;
    if (v[35:32] == {4{v[35]}}) r = v[ArW-1:0];
    else if (!v[35])            r = {1'b0, {32{1'b1}}};
    else                        r = {1'b1, 32'b0};
    return r;
  endfunction

  state_t           state_r, state_nxt;
  mkind_t           mkind_r, mkind_nxt;
  logic [IdxW-1:0]  m_r, m_nxt, jx_r, jx_nxt, j_r, j_nxt, step_r, step_nxt;
  logic [FtW-1:0]   failt_r, failt_nxt;
  logic [COUNT_BITS-1:0] lost_r, lost_nxt;
  logic [ArW-1:0]   a_r, a_nxt, at_risk_r, at_risk_nxt;
  logic [ProbW-1:0] surv_r, surv_nxt, haz_r, haz_nxt, sdd_r, sdd_nxt;
  logic [GwW-1:0]   gw_r, gw_nxt;
  logic [UnitW-1:0] rem_r, rem_nxt, acc_r, acc_nxt;
  logic [35:0]      quo_r, quo_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [MulXW-1:0] mx_r, mx_nxt, my_r, my_nxt;
  logic [66:0]      d_r, d_nxt;
  logic [59:0]      sqv_r, sqv_nxt;
  logic [29:0]      root_r, root_nxt;
  logic             row1_r, row1_nxt, fin_r, fin_nxt;
  logic [PosW-1:0]  ppos_r, ppos_nxt;
  logic [ProbW-1:0] pprob_r, pprob_nxt;
  logic             ov_r, ov_nxt, olast_r, olast_nxt;
  logic [PosW-1:0]  opos_r, opos_nxt;
  logic [ProbW-1:0] oprob_r, oprob_nxt;
  logic [31:0]      oerr_r, oerr_nxt;

  logic [UnitW-1:0] opa, opb, diff;
  logic             ge;
  logic [MulYW-1:0] my_part;
  logic [MulPW-1:0] prod;

  logic [IdxW-1:0]  m_c;
  logic [IdxW:0]    jx_c;
  logic [35:0]      ext_a, neg_a, b_c, neg_b;
  logic             a_pos, a_neg, b_pos, b_neg, haz_fin;
  logic [ProbW-1:0] haz_val;
  logic [48:0]      gsum;
  logic [29:0]      root_c;
  logic             out_free;

  plse_sub u_sub (.opa(opa), .opb(opb), .diff(diff), .ge(ge));

  assign my_part = (state_r == ST_MLO) ? my_r[MulYW-1:0] : my_r[MulXW-1:MulYW];

  plse_mul u_mul (.clk(clk), .x(mx_r), .y(my_part), .p_r(prod));

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = ov_r;
  assign out_position    = opos_r;
  assign out_probability = oprob_r;
  assign out_std_error   = oerr_r;
  assign out_last_of_run = olast_r;
  assign out_free        = !ov_r || !out_stall;

  assign ext_a = {{3{a_r[ArW-1]}}, a_r};
  assign neg_a = -ext_a;
  assign b_c   = ext_a - 36'(failt_r);
  assign neg_b = -b_c;
  assign a_neg = a_r[ArW-1];
  assign a_pos = !a_r[ArW-1] && (a_r != '0);
  assign b_neg = b_c[35];
  assign b_pos = !b_c[35] && (b_c != '0);

  // Operand select for the shared subtractor.
  always_comb begin
    opa = '0;
    opb = '0;
    case (state_r)
      ST_HCHK: begin
        opa = UnitW'(failt_r);
        opb = UnitW'(a_r[31:0]);
      end
      ST_HDIV: begin
        opa = {rem_r[UnitW-2:0], 1'b0};
        opb = UnitW'(a_r[31:0]);
      end
      ST_GDIV: begin
        opa = {rem_r[UnitW-2:0], 1'b0};
        opb = {1'b0, d_r};
      end
      ST_SQ: begin
        opa = {rem_r[UnitW-3:0], sqv_r[59:58]};
        opb = UnitW'({root_r, 2'b01});
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    mkind_nxt   = mkind_r;
    m_nxt       = m_r;
    jx_nxt      = jx_r;
    j_nxt       = j_r;
    step_nxt    = step_r;
    failt_nxt   = failt_r;
    lost_nxt    = lost_r;
    a_nxt       = a_r;
    at_risk_nxt = at_risk_r;
    surv_nxt    = surv_r;
    haz_nxt     = haz_r;
    sdd_nxt     = sdd_r;
    gw_nxt      = gw_r;
    rem_nxt     = rem_r;
    acc_nxt     = acc_r;
    quo_nxt     = quo_r;
    cnt_nxt     = cnt_r;
    mx_nxt      = mx_r;
    my_nxt      = my_r;
    d_nxt       = d_r;
    sqv_nxt     = sqv_r;
    root_nxt    = root_r;
    row1_nxt    = row1_r;
    fin_nxt     = fin_r;
    ppos_nxt    = ppos_r;
    pprob_nxt   = pprob_r;
    ov_nxt      = ov_r && out_stall;
    opos_nxt    = opos_r;
    oprob_nxt   = oprob_r;
    oerr_nxt    = oerr_r;
    olast_nxt   = olast_r;
    m_c         = (cfg.interval_count == '0) ? 13'd1 : cfg.interval_count;
    if ({19'b0, m_c} > 32'(MAX_INTERVALS)) m_c = 13'(MAX_INTERVALS);
    jx_c        = {1'b0, step_r} + 14'd1;
    if (jx_c > {1'b0, m_c}) jx_c = {1'b0, m_c};
    haz_fin     = 1'b0;
    haz_val     = '0;
    gsum        = {1'b0, gw_r} + 49'(quo_r);
    root_c      = ge ? {root_r[28:0], 1'b1} : {root_r[28:0], 1'b0};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          m_nxt     = m_c;
          jx_nxt    = jx_c[IdxW-1:0];
          j_nxt     = cfg.reverse_mode ? (m_c - jx_c[IdxW-1:0] + 13'd1) : jx_c[IdxW-1:0];
          failt_nxt = FtW'(in_failures_first_kind) + FtW'(in_failures_second_kind);
          lost_nxt  = in_lost_count;
          a_nxt     = sat_ar({{3{at_risk_r[ArW-1]}}, at_risk_r} + 36'(in_entering_count));
          state_nxt = ST_HCHK;
        end
      end
      ST_HCHK: begin
        if (!a_pos) begin
          haz_fin = 1'b1;
        end else if (ge) begin
          haz_fin = 1'b1;
          haz_val = ONE_Q31;
        end else begin
          rem_nxt   = UnitW'(failt_r);
          quo_nxt   = '0;
          cnt_nxt   = 6'd30;
          state_nxt = ST_HDIV;
        end
      end
      ST_HDIV: begin
        rem_nxt = ge ? diff : opa;
        quo_nxt = {quo_r[34:0], ge};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          haz_fin = 1'b1;
          haz_val = {1'b0, quo_r[29:0], ge};
        end
      end
      ST_MLO: state_nxt = ST_MHI;
      ST_MHI: begin
        acc_nxt   = UnitW'(prod);
        state_nxt = ST_MADD;
      end
      ST_MADD: begin
        acc_nxt = acc_r + (UnitW'(prod) << MulYW);
        unique case (mkind_r)
          MK_SURV: begin
            surv_nxt  = acc_nxt[62:31];
            state_nxt = ST_GCHK;
          end
          MK_DEN: begin
            d_nxt     = acc_nxt[66:0];
            rem_nxt   = UnitW'(failt_r);
            quo_nxt   = '0;
            cnt_nxt   = 6'd35;
            state_nxt = ST_GDIV;
          end
          default: begin
            sdd_nxt   = acc_nxt[62:31];
            state_nxt = ST_AR;
          end
        endcase
      end
      ST_GCHK: begin
        if ((a_pos && b_pos) || (a_neg && b_neg)) begin
          mx_nxt    = a_neg ? neg_a[MulXW-1:0] : ext_a[MulXW-1:0];
          my_nxt    = b_neg ? neg_b[MulXW-1:0] : b_c[MulXW-1:0];
          mkind_nxt = MK_DEN;
          state_nxt = ST_MLO;
        end else begin
          sdd_nxt   = '0;
          state_nxt = ST_AR;
        end
      end
      ST_GDIV: begin
        rem_nxt = ge ? diff : opa;
        quo_nxt = {quo_r[34:0], ge};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) state_nxt = ST_GSUM;
      end
      ST_GSUM: begin
        gw_nxt    = gsum[GwW] ? GW_MAX : gsum[GwW-1:0];
        sqv_nxt   = {gw_nxt, 12'b0};
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = 6'd29;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        rem_nxt  = ge ? diff : opa;
        root_nxt = root_c;
        sqv_nxt  = {sqv_r[57:0], 2'b00};
        cnt_nxt  = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          mx_nxt    = {2'b00, surv_r};
          my_nxt    = MulXW'(root_c);
          mkind_nxt = MK_ERR;
          state_nxt = ST_MLO;
        end
      end
      ST_AR: begin
        at_risk_nxt = sat_ar(ext_a - 36'(failt_r) - 36'(lost_r));
        if (cfg.reverse_mode) begin
          row1_nxt  = (j_r < cfg.reverse_stop_index) && (j_r != 13'd1);
          ppos_nxt  = PosW'(j_r - 13'd2);
          pprob_nxt = surv_r;
        end else begin
          row1_nxt  = (j_r >= cfg.forward_start_index);
          ppos_nxt  = PosW'(j_r - 13'd1);
          pprob_nxt = ONE_Q31 - surv_r;
        end
        fin_nxt  = (jx_r == m_r);
        step_nxt = jx_r;
        if (jx_r == m_r) begin
          at_risk_nxt = '0;
          surv_nxt    = ONE_Q31;
          gw_nxt      = '0;
          step_nxt    = '0;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!row1_r) begin
          state_nxt = fin_r ? ST_FINAL : ST_IDLE;
        end else if (out_free) begin
          ov_nxt    = 1'b1;
          opos_nxt  = ppos_r;
          oprob_nxt = pprob_r;
          oerr_nxt  = sdd_r;
          olast_nxt = 1'b0;
          state_nxt = fin_r ? ST_FINAL : ST_IDLE;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          opos_nxt  = PosW'(m_r - 13'd1);
          oprob_nxt = ONE_Q31;
          oerr_nxt  = '0;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (haz_fin) begin
      haz_nxt   = haz_val;
      mx_nxt    = {2'b00, surv_r};
      my_nxt    = {2'b00, ONE_Q31 - haz_val};
      mkind_nxt = MK_SURV;
      state_nxt = ST_MLO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      at_risk_r <= '0;
      surv_r    <= ONE_Q31;
      gw_r      <= '0;
      step_r    <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      at_risk_r <= at_risk_nxt;
      surv_r    <= surv_nxt;
      gw_r      <= gw_nxt;
      step_r    <= step_nxt;
      ov_r      <= ov_nxt;
    end
    mkind_r <= mkind_nxt;
    m_r     <= m_nxt;
    jx_r    <= jx_nxt;
    j_r     <= j_nxt;
    failt_r <= failt_nxt;
    lost_r  <= lost_nxt;
    a_r     <= a_nxt;
    haz_r   <= haz_nxt;
    sdd_r   <= sdd_nxt;
    rem_r   <= rem_nxt;
    acc_r   <= acc_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    mx_r    <= mx_nxt;
    my_r    <= my_nxt;
    d_r     <= d_nxt;
    sqv_r   <= sqv_nxt;
    root_r  <= root_nxt;
    row1_r  <= row1_nxt;
    fin_r   <= fin_nxt;
    ppos_r  <= ppos_nxt;
    pprob_r <= pprob_nxt;
    opos_r  <= opos_nxt;
    oprob_r <= oprob_nxt;
    oerr_r  <= oerr_nxt;
    olast_r <= olast_nxt;
  end

endmodule

### hdl/product_limit_survival_estimator.sv
// Top level of the product-limit survival estimator with Greenwood error.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_stall    entering, two failure kinds, lost counts
// out_      output     out_valid/out_stall  position, probability, std_error, last_of_run
// cfg       APB        psel/penable/pready  four registers at byte addresses 0, 4, 8, 12
//
// With failures below the at-risk count and the Greenwood term applying, an item runs a 31-step
// hazard division, a 36-step Greenwood division and a 30-step square root on the shared
// compare-and-subtract unit and three two-pass multiplies. Failures at or above that count skip
// the hazard division; no Greenwood term skips the Greenwood division, the square root and their
// two multiplies. The last interval adds a closing row. Reset is synchronous, active low.
// A stalled row holds while the next item is taken; a closing row waits for the output register.

module product_limit_survival_estimator
  import plse_pkg::*;
#(
  parameter int MAX_INTERVALS = 4096,
  parameter int COUNT_BITS    = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COUNT_BITS-1:0] in_entering_count,
  input  logic [COUNT_BITS-1:0] in_failures_first_kind,
  input  logic [COUNT_BITS-1:0] in_failures_second_kind,
  input  logic [COUNT_BITS-1:0] in_lost_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PosW-1:0]       out_position,
  output logic [ProbW-1:0]      out_probability,
  output logic [31:0]           out_std_error,
  output logic                  out_last_of_run,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AddrW-1:0]      paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t cfg;

  // The register bank never inserts wait states.
  assign pready = 1'b1;

  plse_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .cfg    (cfg)
  );

  // The sequencer holds the at-risk count, the survival product and the Greenwood sum,
  // and owns the shared arithmetic units.
  plse_seq #(
    .MAX_INTERVALS(MAX_INTERVALS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_seq (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_entering_count      (in_entering_count),
    .in_failures_first_kind (in_failures_first_kind),
    .in_failures_second_kind(in_failures_second_kind),
    .in_lost_count          (in_lost_count),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_position           (out_position),
    .out_probability        (out_probability),
    .out_std_error          (out_std_error),
    .out_last_of_run        (out_last_of_run)
  );

endmodule

### hdl/plse_chk.sv
// Port-level checker for the survival estimator and its bind.
`timescale 1ns / 1ps

module plse_chk
  import plse_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PosW-1:0]  out_position,
  input logic [ProbW-1:0] out_probability,
  input logic [31:0]      out_std_error,
  input logic             out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_position) &&
      $stable(out_probability) && $stable(out_std_error) && $stable(out_last_of_run))
    else $error("stalled row changed");

  a_final_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> out_probability == ONE_Q31 && out_std_error == '0)
    else $error("final row is not probability one with zero error");

  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_probability <= ONE_Q31)
    else $error("probability above one");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block took an item without going busy");

endmodule

bind product_limit_survival_estimator plse_chk u_plse_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_position   (out_position),
  .out_probability(out_probability),
  .out_std_error  (out_std_error),
  .out_last_of_run(out_last_of_run)
);
